FILE: hw/rtl/hsvc_pkg.sv
// Shared constants, types and helper functions of the HSV to RGB converter.
package hsvc_pkg;

  // Fixed-point format of saturation, brightness and the color components.
  localparam int FRAC_BITS = 12;
  localparam int CW        = FRAC_BITS + 1;
  localparam logic [CW-1:0] ONE = CW'(1 << FRAC_BITS);

  // Hue in 1/64 degree: a full turn and one of its six sectors.
  localparam int HUE_W = 15;
  localparam logic [HUE_W-1:0] HUE_FULL   = 15'd23040;
  localparam logic [HUE_W-1:0] HUE_SECTOR = 15'd3840;
  localparam int SEC_REM_W = 12;

  // frac = rem * 4096 / 3840 = (rem * 16) / 15. The division by 15 is a
  // multiplication by ceil(2^20 / 15); the error stays below 1/15 for every
  // remainder inside a sector, so the floor is exact.
  localparam int FRAC_X_W = SEC_REM_W + 4;
  localparam logic [16:0] FRAC_RECIP = 17'd69906;
  localparam int FRAC_RECIP_SHIFT = 20;

  // Configuration registers.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] CFG_HUE_SOURCE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_COUNT  = 1'd1;
  localparam logic [CFG_DATA_W-1:0] BIN_COUNT_RST = 9'd16;

  // Sector codes, named after the two corners of the color circle they span.
  localparam logic [2:0] SECT_RED_YELLOW    = 3'd0;
  localparam logic [2:0] SECT_YELLOW_GREEN  = 3'd1;
  localparam logic [2:0] SECT_GREEN_CYAN    = 3'd2;
  localparam logic [2:0] SECT_CYAN_BLUE     = 3'd3;
  localparam logic [2:0] SECT_BLUE_MAGENTA  = 3'd4;
  localparam logic [2:0] SECT_MAGENTA_RED   = 3'd5;

  // Pipelined restoring divider geometry.
  localparam int BIN_W      = 16;
  localparam int DIV_REM_W  = 9;
  localparam int DIV_NUM_W  = BIN_W;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = DIV_NUM_W / DIV_STEPS;
  localparam int SCALED_W   = DIV_REM_W + HUE_W;

  // Partial remainder and the dividend bits still to go; quotient bits
  // shift into the low end of num as dividend bits leave the top.
  typedef struct packed {
    logic [DIV_REM_W-1:0] rem;
    logic [DIV_NUM_W-1:0] num;
  } div_word_t;

  // Fields that ride along with an item through the dividers.
  typedef struct packed {
    logic [HUE_W-1:0] hue_in;
    logic [CW-1:0]    sat;
    logic [CW-1:0]    bri;
  } side_t;

  // Result of the shading pipeline, before the sector permutation.
  typedef struct packed {
    logic          ok;
    logic [2:0]    sector;
    logic [CW-1:0] v;
    logic [CW-1:0] m;
    logic [CW-1:0] n;
  } shade_t;

  function automatic div_word_t div_chunk(div_word_t w, logic [DIV_REM_W-1:0] d);
    div_word_t           res;
    logic [DIV_REM_W:0]  trial;
    res = w;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial   = {res.rem, res.num[DIV_NUM_W-1]};
      res.num = {res.num[DIV_NUM_W-2:0], 1'b0};
      if (trial >= {1'b0, d}) begin
        trial      = trial - {1'b0, d};
        res.num[0] = 1'b1;
      end
      res.rem = trial[DIV_REM_W-1:0];
    end
    return res;
  endfunction

  function automatic logic [2:0] sector_of(logic [HUE_W-1:0] hue);
    logic [2:0] sec;
    sec = 3'd0;
    for (int i = 1; i < 6; i++) begin
      if (hue >= HUE_W'(i * int'(HUE_SECTOR))) sec = sec + 3'd1;
    end
    return sec;
  endfunction

  function automatic logic [HUE_W-1:0] sector_base(logic [2:0] sec);
    return HUE_W'(int'(sec) * int'(HUE_SECTOR));
  endfunction

  function automatic logic [CW-1:0] clamp_one(logic [CW-1:0] x);
    return (x > ONE) ? ONE : x;
  endfunction

endpackage

FILE: hw/rtl/hsvc_div.sv
// Pipelined restoring divider: 9-bit divisor, four quotient bits per stage.
module hsvc_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          in_vld,
  input  logic [hsvc_pkg::DIV_REM_W-1:0] in_rem,
  input  logic [hsvc_pkg::DIV_NUM_W-1:0] in_num,
  input  hsvc_pkg::side_t               in_side,
  input  logic [hsvc_pkg::DIV_REM_W-1:0] divisor,
  output logic                          out_vld,
  output logic [hsvc_pkg::DIV_NUM_W-1:0] out_quo,
  output logic [hsvc_pkg::DIV_REM_W-1:0] out_rem,
  output hsvc_pkg::side_t               out_side
);

  localparam int NSTG = hsvc_pkg::DIV_STAGES;

  hsvc_pkg::div_word_t word_in  [NSTG];
  hsvc_pkg::div_word_t word_nxt [NSTG];
  hsvc_pkg::div_word_t word_r   [NSTG];
  hsvc_pkg::side_t     side_in  [NSTG];
  hsvc_pkg::side_t     side_r   [NSTG];
  logic [NSTG-1:0]     vld_in;
  logic [NSTG-1:0]     vld_r;

  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    if (s == 0) begin : g_first
      assign word_in[s] = {in_rem, in_num};
      assign side_in[s] = in_side;
      assign vld_in[s]  = in_vld;
    end else begin : g_next
      assign word_in[s] = word_r[s-1];
      assign side_in[s] = side_r[s-1];
      assign vld_in[s]  = vld_r[s-1];
    end

    assign word_nxt[s] = hsvc_pkg::div_chunk(word_in[s], divisor);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (adv) begin
        vld_r[s] <= vld_in[s];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        word_r[s] <= word_nxt[s];
        side_r[s] <= side_in[s];
      end
    end
  end

  assign out_vld  = vld_r[NSTG-1];
  assign out_quo  = word_r[NSTG-1].num;
  assign out_rem  = word_r[NSTG-1].rem;
  assign out_side = side_r[NSTG-1];

endmodule

FILE: hw/rtl/hsvc_rgb.sv
// Four-stage shading pipeline: sector split, sector fraction and the three products.
module hsvc_rgb (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic                      in_vld,
  input  logic [hsvc_pkg::HUE_W-1:0] in_hue,
  input  logic [hsvc_pkg::CW-1:0]   in_sat,
  input  logic [hsvc_pkg::CW-1:0]   in_bri,
  output logic                      out_vld,
  output hsvc_pkg::shade_t          out_shade
);

  localparam int CW = hsvc_pkg::CW;
  localparam int FRAC_BITS_W = hsvc_pkg::FRAC_BITS;
  localparam int FRAC_PROD_W = hsvc_pkg::FRAC_X_W + 17;

  // Stage 1: sector and remainder within it, clamped saturation and value.
  logic                            vld1_r, ok1_r;
  logic [2:0]                      sec1_r;
  logic [hsvc_pkg::SEC_REM_W-1:0]  rem1_r;
  logic [CW-1:0]                   s1_r, v1_r;
  logic [2:0]                      sec1_nxt;
  logic [hsvc_pkg::HUE_W-1:0]      rem1_full;

  // Stage 2: position within the sector and the low component.
  logic                            vld2_r, ok2_r;
  logic [2:0]                      sec2_r;
  logic [FRAC_BITS_W-1:0]          frac2_r;
  logic [CW-1:0]                   s2_r, v2_r, m2_r;
  logic [FRAC_PROD_W-1:0]          frac_prod;
  logic [2*CW-1:0]                 m_prod;

  // Stage 3: saturation scaled by the ramp.
  logic                            vld3_r, ok3_r;
  logic [2:0]                      sec3_r;
  logic [CW-1:0]                   t3_r, v3_r, m3_r;
  logic [CW-1:0]                   f3;
  logic [2*CW-1:0]                 t_prod;

  // Stage 4: the middle component.
  logic                            vld4_r;
  hsvc_pkg::shade_t                shade4_r;
  logic [2*CW-1:0]                 n_prod;

  assign sec1_nxt  = hsvc_pkg::sector_of(in_hue);
  assign rem1_full = in_hue - hsvc_pkg::sector_base(sec1_nxt);

  assign frac_prod = FRAC_PROD_W'({rem1_r, 4'b0000}) * FRAC_PROD_W'(hsvc_pkg::FRAC_RECIP);
  assign m_prod    = (2*CW)'(v1_r) * (2*CW)'(hsvc_pkg::ONE - s1_r);

  assign f3     = sec2_r[0] ? {1'b0, frac2_r} : (hsvc_pkg::ONE - {1'b0, frac2_r});
  assign t_prod = (2*CW)'(s2_r) * (2*CW)'(f3);

  assign n_prod = (2*CW)'(v3_r) * (2*CW)'(hsvc_pkg::ONE - t3_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else if (adv) begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ok1_r  <= in_hue < hsvc_pkg::HUE_FULL;
      sec1_r <= sec1_nxt;
      rem1_r <= rem1_full[hsvc_pkg::SEC_REM_W-1:0];
      s1_r   <= hsvc_pkg::clamp_one(in_sat);
      v1_r   <= hsvc_pkg::clamp_one(in_bri);

      ok2_r   <= ok1_r;
      sec2_r  <= sec1_r;
      frac2_r <= frac_prod[hsvc_pkg::FRAC_RECIP_SHIFT+FRAC_BITS_W-1:
                           hsvc_pkg::FRAC_RECIP_SHIFT];
      s2_r    <= s1_r;
      v2_r    <= v1_r;
      m2_r    <= m_prod[FRAC_BITS_W+CW-1:FRAC_BITS_W];

      ok3_r  <= ok2_r;
      sec3_r <= sec2_r;
      t3_r   <= t_prod[FRAC_BITS_W+CW-1:FRAC_BITS_W];
      v3_r   <= v2_r;
      m3_r   <= m2_r;

      shade4_r.ok     <= ok3_r;
      shade4_r.sector <= sec3_r;
      shade4_r.v      <= v3_r;
      shade4_r.m      <= m3_r;
      shade4_r.n      <= n_prod[FRAC_BITS_W+CW-1:FRAC_BITS_W];
    end
  end

  assign out_vld   = vld4_r;
  assign out_shade = shade4_r;

endmodule

FILE: hw/rtl/hsv_color_from_hue_or_bin_top.sv
// Top level of the HSV to RGB converter with direct or binned hue.
// The converter takes one beat per clock while the output is not stalled
// and returns one beat per input beat. Each beat passes through two
// 4-stage restoring dividers (bin index modulo bin count, then the scaled bin
// divided by the count), one multiply stage between them, four shading stages
// and the output register. Every beat runs the full pipeline in both hue
// modes. A stall on the output freezes the whole pipeline; in_ready is low
// exactly while a finished beat waits and out_ready is low. Configuration
// writes land at once and must only happen while no beat is in flight. A hue
// at or above 360 degrees gives a beat with color_valid low and all
// components zero.
module hsv_color_from_hue_or_bin_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [14:0]                    in_hue_in,
  input  logic [15:0]                    in_bin_index,
  input  logic [12:0]                    in_saturation,
  input  logic [12:0]                    in_brightness,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [12:0]                    out_red,
  output logic [12:0]                    out_green,
  output logic [12:0]                    out_blue,
  output logic                           out_color_valid,
  input  logic                           cfg_we,
  input  logic [hsvc_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [hsvc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CW = hsvc_pkg::CW;

  // Configuration registers.
  logic                            hue_src_r;
  logic [hsvc_pkg::CFG_DATA_W-1:0] bin_cnt_r;
  logic [hsvc_pkg::DIV_REM_W-1:0]  divisor;

  // The whole pipeline moves together whenever the output can move.
  logic adv;

  // Bin index modulo the bin count.
  hsvc_pkg::side_t                 side_in;
  logic                            d1_vld;
  logic [hsvc_pkg::DIV_REM_W-1:0]  d1_rem;
  hsvc_pkg::side_t                 d1_side;

  // Bin scaled to a full turn.
  logic                            sc_vld_r;
  logic [hsvc_pkg::SCALED_W-1:0]   sc_num_r;
  hsvc_pkg::side_t                 sc_side_r;

  // Scaled bin divided by the count gives the derived hue.
  logic                            d2_vld;
  logic [hsvc_pkg::DIV_NUM_W-1:0]  d2_quo;
  hsvc_pkg::side_t                 d2_side;
  logic [hsvc_pkg::HUE_W-1:0]      hue_sel;

  // Shading pipeline and output register.
  logic                            sh_vld;
  hsvc_pkg::shade_t                shade;
  logic                            out_valid_r;
  logic [CW-1:0]                   red_r, green_r, blue_r;
  logic                            color_valid_r;
  logic [CW-1:0]                   red_nxt, green_nxt, blue_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_src_r <= 1'b0;
      bin_cnt_r <= hsvc_pkg::BIN_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        hsvc_pkg::CFG_HUE_SOURCE: hue_src_r <= cfg_wdata[0];
        hsvc_pkg::CFG_BIN_COUNT:  bin_cnt_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // A bin count of zero behaves as a count of one.
  assign divisor = (bin_cnt_r == '0) ? hsvc_pkg::DIV_REM_W'(1) : bin_cnt_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  assign side_in = {in_hue_in, in_saturation, in_brightness};

  hsvc_div u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (in_valid),
    .in_rem   ('0),
    .in_num   (in_bin_index),
    .in_side  (side_in),
    .divisor  (divisor),
    .out_vld  (d1_vld),
    .out_quo  (),
    .out_rem  (d1_rem),
    .out_side (d1_side)
  );

  // The remainder is below the count, so the product is below count * 2^15
  // and its top bits already form a valid starting remainder for the second
  // divider.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_vld_r <= 1'b0;
    end else if (adv) begin
      sc_vld_r <= d1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sc_num_r  <= hsvc_pkg::SCALED_W'(d1_rem) * hsvc_pkg::SCALED_W'(hsvc_pkg::HUE_FULL);
      sc_side_r <= d1_side;
    end
  end

  hsvc_div u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (sc_vld_r),
    .in_rem   ({1'b0, sc_num_r[hsvc_pkg::SCALED_W-1:hsvc_pkg::DIV_NUM_W]}),
    .in_num   (sc_num_r[hsvc_pkg::DIV_NUM_W-1:0]),
    .in_side  (sc_side_r),
    .divisor  (divisor),
    .out_vld  (d2_vld),
    .out_quo  (d2_quo),
    .out_rem  (),
    .out_side (d2_side)
  );

  assign hue_sel = hue_src_r ? d2_quo[hsvc_pkg::HUE_W-1:0] : d2_side.hue_in;

  hsvc_rgb u_rgb (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_vld    (d2_vld),
    .in_hue    (hue_sel),
    .in_sat    (d2_side.sat),
    .in_bri    (d2_side.bri),
    .out_vld   (sh_vld),
    .out_shade (shade)
  );

  // Place the full, low and middle components according to the sector.
  always_comb begin
    case (shade.sector)
      hsvc_pkg::SECT_RED_YELLOW: begin
        red_nxt = shade.v; green_nxt = shade.n; blue_nxt = shade.m;
      end
      hsvc_pkg::SECT_YELLOW_GREEN: begin
        red_nxt = shade.n; green_nxt = shade.v; blue_nxt = shade.m;
      end
      hsvc_pkg::SECT_GREEN_CYAN: begin
        red_nxt = shade.m; green_nxt = shade.v; blue_nxt = shade.n;
      end
      hsvc_pkg::SECT_CYAN_BLUE: begin
        red_nxt = shade.m; green_nxt = shade.n; blue_nxt = shade.v;
      end
      hsvc_pkg::SECT_BLUE_MAGENTA: begin
        red_nxt = shade.n; green_nxt = shade.m; blue_nxt = shade.v;
      end
      default: begin
        red_nxt = shade.v; green_nxt = shade.m; blue_nxt = shade.n;
      end
    endcase
    if (!shade.ok) begin
      red_nxt   = '0;
      green_nxt = '0;
      blue_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= sh_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      red_r         <= red_nxt;
      green_r       <= green_nxt;
      blue_r        <= blue_nxt;
      color_valid_r <= shade.ok;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_red         = red_r;
  assign out_green       = green_r;
  assign out_blue        = blue_r;
  assign out_color_valid = color_valid_r;

  // The modulo stage always leaves a remainder below the effective count.
  a_mod_below_count: assert property (@(posedge clk) disable iff (!rst_n)
    d1_vld |-> d1_rem < divisor)
    else $error("bin remainder not below bin count");

  // A hue derived from a bin always lies inside the color circle.
  a_bin_hue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    d2_vld && hue_src_r |-> d2_quo < hsvc_pkg::DIV_NUM_W'(hsvc_pkg::HUE_FULL))
    else $error("derived hue outside the color circle");

  // A beat without a color carries zero components.
  a_no_color_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !color_valid_r |-> red_r == '0 && green_r == '0 && blue_r == '0)
    else $error("components not zero for an invalid hue");

  // Components never exceed one.
  a_comp_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> red_r <= hsvc_pkg::ONE && green_r <= hsvc_pkg::ONE &&
                    blue_r <= hsvc_pkg::ONE)
    else $error("color component above one");

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the HSV to RGB converter with direct or binned hue.
module tb;
  import hsvc_pkg::*;

  // One expected output beat: the three components and the in-range flag.
  typedef struct packed {
    logic [CW-1:0] red;
    logic [CW-1:0] green;
    logic [CW-1:0] blue;
    logic          ok;
  } rgb_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [14:0]           in_hue_in = '0;
  logic [15:0]           in_bin_index = '0;
  logic [12:0]           in_saturation = '0;
  logic [12:0]           in_brightness = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b1;
  logic [12:0]           out_red;
  logic [12:0]           out_green;
  logic [12:0]           out_blue;
  logic                  out_color_valid;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Our own copy of the two configuration registers, at their reset values.
  logic                  mode_bins = 1'b0;
  logic [CFG_DATA_W-1:0] bins_per_turn = BIN_COUNT_RST;

  // Colors that accepted beats must still produce, oldest first.
  rgb_t pending_rgb[$];
  int   err_count = 0;

  // Sender gap probability in percent, and a switch that turns off all idling
  // on both sides for the closing full-rate part of the run.
  int   gap_pct = 0;
  logic calm = 1'b0;
  int   ready_hold = 0;

  hsv_color_from_hue_or_bin_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_hue_in       (in_hue_in),
    .in_bin_index    (in_bin_index),
    .in_saturation   (in_saturation),
    .in_brightness   (in_brightness),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_color_valid (out_color_valid),
    .cfg_we          (cfg_we),
    .cfg_idx         (cfg_idx),
    .cfg_wdata       (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Hard stop in case the converter hangs; a correct run needs far less.
  initial begin
    #10_000_000;
    $display("tb failed");
    $finish;
  end

  // Expected color for one input beat under the current register copy. The
  // hue is taken directly or derived from the bin, then split into a sector
  // and a position inside it. The low component is v(1-s), the middle one is
  // v(1-s*f) where f runs forward in odd sectors and backward in even ones.
  // Every product truncates, and a hue past a full turn gives a dark,
  // invalid beat.
  function automatic rgb_t convert_hsv(input logic [14:0] hue_field,
                                       input logic [15:0] bin_field,
                                       input logic [12:0] sat_field,
                                       input logic [12:0] bri_field);
    rgb_t        res;
    int unsigned hue, cnt, s, v, rem, frac, f, low, mid;
    logic [2:0]  sector;
    res = '0;
    // Saturation and brightness above one are clipped to one.
    s = (sat_field > ONE) ? 32'(ONE) : 32'(sat_field);
    v = (bri_field > ONE) ? 32'(ONE) : 32'(bri_field);
    if (mode_bins) begin
      // A bin count of zero behaves like a single bin.
      cnt = (bins_per_turn == 0) ? 1 : 32'(bins_per_turn);
      hue = ((32'(bin_field) % cnt) * 32'(HUE_FULL)) / cnt;
    end else begin
      hue = 32'(hue_field);
    end
    if (hue < HUE_FULL) begin
      sector = 3'(hue / HUE_SECTOR);
      rem    = hue % HUE_SECTOR;
      frac   = (rem << FRAC_BITS) / HUE_SECTOR;
      f      = sector[0] ? frac : ONE - frac;
      low    = (v * (ONE - s)) >> FRAC_BITS;
      mid    = (v * (ONE - ((s * f) >> FRAC_BITS))) >> FRAC_BITS;
      res.ok = 1'b1;
      case (sector)
        SECT_RED_YELLOW: begin
          res.red = CW'(v);   res.green = CW'(mid); res.blue = CW'(low);
        end
        SECT_YELLOW_GREEN: begin
          res.red = CW'(mid); res.green = CW'(v);   res.blue = CW'(low);
        end
        SECT_GREEN_CYAN: begin
          res.red = CW'(low); res.green = CW'(v);   res.blue = CW'(mid);
        end
        SECT_CYAN_BLUE: begin
          res.red = CW'(low); res.green = CW'(mid); res.blue = CW'(v);
        end
        SECT_BLUE_MAGENTA: begin
          res.red = CW'(mid); res.green = CW'(low); res.blue = CW'(v);
        end
        default: begin
          res.red = CW'(v);   res.green = CW'(low); res.blue = CW'(mid);
        end
      endcase
    end
    return res;
  endfunction

  // Prints one line per mismatch and counts it.
  task automatic flag_error(input string what);
    $display("ERROR at %0t ns: %s", $time, what);
    err_count++;
  endtask

  // Output side: random stall bursts alternate with ready stretches that may run
  // much longer, so stretches without any stall occur too.
  always @(posedge clk) begin
    if (calm) begin
      out_ready  <= 1'b1;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (out_ready) begin
      out_ready  <= 1'b0;
      ready_hold <= $urandom_range(0, 8);
    end else begin
      out_ready  <= 1'b1;
      ready_hold <= $urandom_range(0, 40);
    end
  end

  // Every output beat is checked field by field against the oldest expected
  // color. Values are sampled at the edge, before any of our drives land.
  always @(posedge clk) begin : color_check
    rgb_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_rgb.size() == 0) begin
        flag_error($sformatf("beat with no color pending: r=%0d g=%0d b=%0d ok=%0b",
                             out_red, out_green, out_blue, out_color_valid));
      end else begin
        want = pending_rgb.pop_front();
        if (out_red !== want.red)
          flag_error($sformatf("red %0d, want %0d", out_red, want.red));
        if (out_green !== want.green)
          flag_error($sformatf("green %0d, want %0d", out_green, want.green));
        if (out_blue !== want.blue)
          flag_error($sformatf("blue %0d, want %0d", out_blue, want.blue));
        if (out_color_valid !== want.ok)
          flag_error($sformatf("color_valid %0b, want %0b", out_color_valid, want.ok));
      end
    end
  end

  // Offers one beat and returns at the edge that accepts it. Valid is left
  // high so the next beat can follow without a bubble; a random gap, when
  // taken, lowers it first.
  task automatic send_hsv(input logic [14:0] hue, input logic [15:0] bin,
                          input logic [12:0] sat, input logic [12:0] bri);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_hue_in     <= hue;
    in_bin_index  <= bin;
    in_saturation <= sat;
    in_brightness <= bri;
    do @(posedge clk); while (!in_ready);
    pending_rgb.push_back(convert_hsv(hue, bin, sat, bri));
  endtask

  // Stops sending and waits until every expected color has come back, then
  // lets the pipeline run empty. Colors that never arrive are failures.
  task automatic wait_drained();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (pending_rgb.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (16) @(posedge clk);
    if (pending_rgb.size() != 0) begin
      flag_error($sformatf("%0d colors never came out", pending_rgb.size()));
      pending_rgb.delete();
    end
  endtask

  // Register writes only happen on an empty pipeline.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    wait_drained();
    case (idx)
      CFG_HUE_SOURCE: mode_bins = data[0];
      default:        bins_per_turn = data;
    endcase
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Saturation or brightness: mostly inside [0, 1], sometimes exactly at an
  // end, sometimes anywhere in the 13-bit field so the clipping is exercised.
  function automatic logic [12:0] pick_level();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return 13'($urandom_range(0, ONE));
    if (sel < 80) return $urandom_range(0, 1) ? ONE : 13'd0;
    return 13'($urandom);
  endfunction

  // Hue: mostly inside the circle, some beyond a full turn, some on the
  // first or last step of a sector.
  function automatic logic [14:0] pick_hue();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 80) return 15'($urandom_range(0, HUE_FULL - 1));
    if (sel < 90) return 15'($urandom_range(HUE_FULL, 32767));
    return 15'($urandom_range(0, 5) * HUE_SECTOR + ($urandom_range(0, 1) ? HUE_SECTOR - 1 : 0));
  endfunction

  // Bin index: mostly the full 16-bit range, some small values near the count.
  function automatic logic [15:0] pick_bin();
    if ($urandom_range(0, 99) < 70) return 16'($urandom);
    return 16'($urandom_range(0, 600));
  endfunction

  // Direct hue: sector edges, both ends of the circle, hues past a full turn,
  // and saturation or brightness at zero, one and above one.
  task automatic check_direct_hues();
    write_reg(CFG_HUE_SOURCE, 9'd0);
    send_hsv(15'd0,     16'($urandom), 13'd4096, 13'd4096);
    send_hsv(15'd3839,  16'($urandom), 13'd4096, 13'd4096);
    send_hsv(15'd3840,  16'($urandom), 13'd4096, 13'd4096);
    send_hsv(15'd9600,  16'($urandom), 13'd2048, 13'd3000);
    send_hsv(15'd11620, 16'($urandom), 13'd4096, 13'd4096);
    send_hsv(15'd18360, 16'($urandom), 13'd1000, 13'd4096);
    send_hsv(15'd21200, 16'($urandom), 13'd4096, 13'd2500);
    send_hsv(15'd23039, 16'($urandom), 13'd4096, 13'd4096);
    send_hsv(15'd23040, 16'($urandom), 13'd4096, 13'd4096);
    send_hsv(15'd32767, 16'hFFFF,      13'd8191, 13'd8191);
    send_hsv(15'd5000,  16'($urandom), 13'd0,    13'd4096);
    send_hsv(15'd17000, 16'($urandom), 13'd8191, 13'd8191);
    send_hsv(15'd1234,  16'($urandom), 13'd4096, 13'd0);
    send_hsv(15'd7679,  16'($urandom), 13'd4097, 13'd4097);
  endtask

  // Binned hue at the count extremes: zero acts as one bin, and counts above
  // 256 are used as written.
  task automatic check_bin_special_counts();
    write_reg(CFG_HUE_SOURCE, 9'd1);
    send_hsv(15'($urandom), 16'hFFFF,   13'd4096, 13'd4096);
    write_reg(CFG_BIN_COUNT, 9'd0);
    send_hsv(15'($urandom), 16'd12345,  13'd3000, 13'd4096);
    write_reg(CFG_BIN_COUNT, 9'd1);
    send_hsv(15'($urandom), 16'hFFFF,   13'd4096, 13'd2000);
    write_reg(CFG_BIN_COUNT, 9'd256);
    send_hsv(15'($urandom), 16'd255,    13'd4096, 13'd4096);
    send_hsv(15'($urandom), 16'hFFFF,   13'd2500, 13'd4096);
    write_reg(CFG_BIN_COUNT, 9'd511);
    send_hsv(15'($urandom), 16'd510,    13'd4096, 13'd4096);
    write_reg(CFG_BIN_COUNT, 9'd300);
    send_hsv(15'($urandom), 16'd299,    13'd4096, 13'd3500);
  endtask

  // Random direct hues in blocks with different sender gap rates. Halfway the
  // sender holds off until every pending color has come out.
  task automatic check_random_hues();
    int gaps[4] = '{0, 10, 30, 60};
    write_reg(CFG_HUE_SOURCE, 9'd0);
    for (int blk = 0; blk < 8; blk++) begin
      gap_pct = gaps[$urandom_range(0, 3)];
      if (blk == 4) wait_drained();
      repeat (100) send_hsv(pick_hue(), 16'($urandom), pick_level(), pick_level());
    end
  endtask

  // Random bins under a range of counts, the extremes among them.
  task automatic check_random_bins();
    int counts[13] = '{2, 3, 6, 7, 16, 45, 100, 255, 256, 0, 1, 300, 511};
    write_reg(CFG_HUE_SOURCE, 9'd1);
    foreach (counts[i]) begin
      write_reg(CFG_BIN_COUNT, 9'(counts[i]));
      gap_pct = $urandom_range(0, 50);
      repeat (70) send_hsv(15'($urandom), pick_bin(), pick_level(), pick_level());
    end
  endtask

  // Closing part at full rate: no gaps on the input and no stalls on the
  // output, first with direct hues and then with bins.
  task automatic check_full_rate();
    calm    <= 1'b1;
    gap_pct = 0;
    write_reg(CFG_HUE_SOURCE, 9'd0);
    repeat (150) send_hsv(pick_hue(), 16'($urandom), pick_level(), pick_level());
    write_reg(CFG_HUE_SOURCE, 9'd1);
    write_reg(CFG_BIN_COUNT, 9'($urandom_range(1, 256)));
    repeat (100) send_hsv(15'($urandom), pick_bin(), pick_level(), pick_level());
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_direct_hues();
    check_bin_special_counts();
    check_random_hues();
    check_random_bins();
    check_full_rate();
    wait_drained();
    if (err_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
